[rtl/i2cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes of the i2c bus master phy: command codes,
// sequencer phase codes, timer width and the beats that move between stages
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TIMER_W = 16;
    localparam int TICKS_W = 16;
    localparam int BYTE_W  = 8;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_STOP   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_ACKCHK = 3'd4;
    localparam logic [2:0] OP_NACK   = 3'd5;

    localparam logic [3:0] PH_0    = 4'd0;
    localparam logic [3:0] PH_1    = 4'd1;
    localparam logic [3:0] PH_2    = 4'd2;
    localparam logic [3:0] PH_3    = 4'd3;
    localparam logic [3:0] PH_IDLE = 4'd15;

    typedef struct packed {
        logic              go;
        logic [2:0]        cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic              sda_in;
    } cmd_beat_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } pins_t;

    typedef struct packed {
        pins_t             pins;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack;
    } res_beat_t;

endpackage

[rtl/i2cm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// accepts tick beats, flags those that carry a legal command and holds
// them in a two-entry queue for the sequencer
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              cmd_valid,
    input  logic [2:0]        cmd,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic              sda_in,
    output logic              q_valid,
    input  logic              q_pop,
    output cmd_beat_t         q_head
);

    cmd_beat_t   entry_reg [2];
    logic        wptr_reg;
    logic        wptr_next;
    logic        rptr_reg;
    logic        rptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;
    cmd_beat_t   beat;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = entry_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        beat.go      = cmd_valid && (cmd <= OP_NACK);
        beat.cmd     = cmd;
        beat.tx_byte = tx_byte;
        beat.sda_in  = sda_in;
    end

    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= beat;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("command queue overfilled");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("command queue lost a beat");

endmodule

[rtl/i2cm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_seq
// pin phase sequencer: one tick per beat, runs start, stop, byte write,
// byte read, ack check and nack phases and emits one result beat per tick
// ----------------------------------------------------------------------------
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data,
    input  logic               q_valid,
    output logic               q_pop,
    input  cmd_beat_t          q_head,
    input  logic               r_ready,
    output logic               r_push,
    output res_beat_t          r_beat
);

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_W) - 33'd1;

    logic [TICKS_W-1:0] ticks_reg;
    logic [3:0]         phase_reg;
    logic [3:0]         phase_next;
    logic [2:0]         op_reg;
    logic [2:0]         op_next;
    logic [3:0]         bits_reg;
    logic [3:0]         bits_next;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [BYTE_W-1:0]  shift_reg;
    logic [BYTE_W-1:0]  shift_next;
    pins_t              pins_reg;
    pins_t              pins_next;
    logic               ack_reg;
    logic               ack_next;
    logic               done;
    logic               finish;
    logic [3:0]         nph;
    logic [TIMER_W-1:0] load;
    logic [32:0]        ticks_wide;

    function automatic pins_t apply_phase(input logic [2:0] op, input logic [3:0] ph,
                                          input pins_t cur, input logic msb);
        pins_t p;
        p = cur;
        unique case (op) inside
            OP_START:
            begin
                if (ph == PH_0)
                begin
                    p.scl = 1'b1;
                    p.sda = 1'b1;
                    p.drv = 1'b1;
                end
                else if (ph == PH_1) p.sda = 1'b0;
                else p.scl = 1'b0;
            end
            OP_STOP:
            begin
                if (ph == PH_0)
                begin
                    p.sda = 1'b0;
                    p.drv = 1'b1;
                end
                else if (ph == PH_1) p.scl = 1'b1;
                else p.sda = 1'b1;
            end
            OP_WRITE:
            begin
                if (ph == PH_0)
                begin
                    p.sda = msb;
                    p.drv = 1'b1;
                end
                else if (ph == PH_1) p.scl = 1'b1;
                else p.scl = 1'b0;
            end
            OP_READ:
            begin
                if (ph == PH_0) p.drv = 1'b0;
                else if (ph == PH_1) p.scl = 1'b1;
                else p.scl = 1'b0;
            end
            OP_ACKCHK:
            begin
                if (ph == PH_0) p.drv = 1'b0;
                else if (ph == PH_1) p.scl = 1'b1;
                else if (ph == PH_2) p.scl = 1'b0;
                else p.drv = 1'b1;
            end
            default:
            begin
                if (ph == PH_0) p.drv = 1'b1;
                else if (ph == PH_1) p.sda = 1'b1;
                else if (ph == PH_2) p.scl = 1'b1;
                else p.scl = 1'b0;
            end
        endcase
        return p;
    endfunction

    assign cfg_ready = 1'b1;
    assign q_pop     = q_valid && r_ready;
    assign r_push    = q_pop;

    // phase length, saturated to the timer and never zero
    always_comb
    begin
        ticks_wide = {{(33 - TICKS_W){1'b0}}, ticks_reg};
        if (ticks_wide > TIMER_MAX)
        begin
            ticks_wide = TIMER_MAX;
        end
        load = ticks_wide[TIMER_W-1:0];
        if (load == '0)
        begin
            load = TIMER_W'(1);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        bits_next  = bits_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        pins_next  = pins_reg;
        ack_next   = ack_reg;
        done       = 1'b0;
        finish     = 1'b0;
        nph        = phase_reg + 4'd1;
        if (q_pop)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (q_head.go)
                begin
                    op_next   = q_head.cmd;
                    bits_next = 4'd0;
                    if (q_head.cmd == OP_WRITE) shift_next = q_head.tx_byte;
                    if (q_head.cmd == OP_READ) shift_next = '0;
                    phase_next = PH_0;
                    pins_next  = apply_phase(q_head.cmd, PH_0, pins_reg,
                                             shift_next[BYTE_W-1]);
                    timer_next = load;
                end
            end
            else if (timer_reg > TIMER_W'(1))
            begin
                timer_next = timer_reg - TIMER_W'(1);
            end
            else
            begin
                if (op_reg == OP_READ && phase_reg == PH_1)
                    shift_next = {shift_reg[BYTE_W-2:0], q_head.sda_in};
                if (op_reg == OP_ACKCHK && phase_reg == PH_1)
                    ack_next = q_head.sda_in;
                if (op_reg == OP_WRITE && phase_reg == PH_2)
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], shift_reg[BYTE_W-1]};
                    bits_next  = bits_reg + 4'd1;
                end
                if (op_reg == OP_READ && phase_reg == PH_2)
                    bits_next = bits_reg + 4'd1;

                unique case (op_reg) inside
                    OP_START, OP_STOP:
                    begin
                        finish = (phase_reg >= PH_2);
                    end
                    OP_WRITE, OP_READ:
                    begin
                        if (phase_reg >= PH_2)
                        begin
                            if (bits_next < BYTE_BITS)
                                nph = (op_reg == OP_WRITE) ? PH_0 : PH_1;
                            else
                                finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = (phase_reg >= PH_3);
                    end
                endcase

                if (finish)
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
                else
                begin
                    phase_next = nph;
                    pins_next  = apply_phase(op_reg, nph, pins_reg,
                                             shift_next[BYTE_W-1]);
                    timer_next = load;
                end
            end
        end
    end

    always_comb
    begin
        r_beat.pins    = pins_next;
        r_beat.busy    = (phase_next != PH_IDLE);
        r_beat.done    = done;
        r_beat.rx_byte = shift_next;
        r_beat.ack     = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_W'(250);
            phase_reg <= PH_IDLE;
            op_reg    <= OP_START;
            bits_reg  <= 4'd0;
            timer_reg <= '0;
            shift_reg <= '0;
            pins_reg  <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            ack_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ticks_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            op_reg    <= op_next;
            bits_reg  <= bits_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            pins_reg  <= pins_next;
            ack_reg   <= ack_next;
        end
    end

    a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (timer_reg != '0))
        else $error("timer expired inside a phase");

    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("timer running while idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (r_push && r_beat.done) |=> (phase_reg == PH_IDLE))
        else $error("done reported while still busy");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !q_pop |=> $stable(phase_reg) && $stable(timer_reg))
        else $error("sequencer moved without a beat");

endmodule

[rtl/i2cm_resq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_resq
// two-entry result queue between the sequencer and the result ports
// ----------------------------------------------------------------------------
module i2cm_resq
    import i2cm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      r_push,
    output logic      r_ready,
    input  res_beat_t r_beat,
    output logic      empty,
    input  logic      pop,
    output res_beat_t head
);

    res_beat_t  entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign r_ready = (count_reg != 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rptr_reg];
    assign do_push = r_push && r_ready;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= ~wptr_reg;
            if (do_pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= r_beat;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue overfilled");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg))
        else $error("result queue pointers out of step");

endmodule

[rtl/i2c_bus_master_phy_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_master_phy_top
// byte level i2c master phy driving scl and sda, one beat per bus tick
// ----------------------------------------------------------------------------
// Each input beat is one tick of the bus timebase and yields exactly one
// result beat holding the pin levels, busy, done, the shift register and the
// last acknowledge level. One beat is taken every clock cycle while full is
// low: the sequencer works each beat out combinationally as it pops it, and
// a two-entry command queue ahead of it and a two-entry result queue behind
// it let both sides stall independently. A beat passes the command queue
// entry and then the result queue entry before it reaches the result ports;
// full rises only once both queues are filled by a stalled pop.
// ----------------------------------------------------------------------------
module i2c_bus_master_phy_top
    import i2cm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               cmd_valid,
    input  logic [2:0]         cmd,
    input  logic [BYTE_W-1:0]  tx_byte,
    input  logic               sda_in,
    output logic               empty,
    input  logic               pop,
    output logic               scl_level,
    output logic               sda_level,
    output logic               sda_drive,
    output logic               busy_res,
    output logic               done_res,
    output logic [BYTE_W-1:0]  rx_byte,
    output logic               ack_seen
);

    logic      q_valid;
    logic      q_pop;
    cmd_beat_t q_head;
    logic      r_ready;
    logic      r_push;
    res_beat_t r_beat;
    res_beat_t head;

    i2cm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .sda_in    (sda_in),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    i2cm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .r_ready   (r_ready),
        .r_push    (r_push),
        .r_beat    (r_beat)
    );

    i2cm_resq u_resq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .r_push  (r_push),
        .r_ready (r_ready),
        .r_beat  (r_beat),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign scl_level = head.pins.scl;
    assign sda_level = head.pins.sda;
    assign sda_drive = head.pins.drv;
    assign busy_res  = head.busy;
    assign done_res  = head.done;
    assign rx_byte   = head.rx_byte;
    assign ack_seen  = head.ack;

endmodule

[dv/i2c_bus_master_phy_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_master_phy_top_tb
// self-checking bench for the i2c bus master phy
// ----------------------------------------------------------------------------
// Every bus tick is pushed as one beat and a local model of the pin sequencer
// predicts the pin levels, busy, done, shift register and acknowledge level
// for it. A separate process pops the result beats, with random stalls, and
// compares each one field by field with the oldest prediction. The run goes
// through the reset tick length, short directed commands, zero and maximum
// tick lengths and long random i2c transfers, with random gaps on both sides
// except in the closing part.
// ----------------------------------------------------------------------------
module i2c_bus_master_phy_top_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 100;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [TICKS_W-1:0] cfg_data;
    logic push;
    logic full;
    logic cmd_valid;
    logic [2:0] cmd;
    logic [BYTE_W-1:0] tx_byte;
    logic sda_in;
    logic empty;
    logic pop;
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic ack_seen;

    // model of the sequencer
    logic [TICKS_W-1:0] ticks_cfg;
    logic [3:0] seq_ph;
    logic [2:0] cur_op;
    logic [3:0] bits_done;
    logic [TIMER_W-1:0] timer_q;
    logic [BYTE_W-1:0] shreg;
    logic scl_q;
    logic sda_q;
    logic drv_q;
    logic ack_q;

    res_beat_t bus_res_q[$];
    int mismatches = 0;
    bit gaps_on = 1'b1;

    i2c_bus_master_phy_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .sda_in    (sda_in),
        .empty     (empty),
        .pop       (pop),
        .scl_level (scl_level),
        .sda_level (sda_level),
        .sda_drive (sda_drive),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .rx_byte   (rx_byte),
        .ack_seen  (ack_seen)
    );

    always #10 clk = ~clk;

    function automatic logic [TIMER_W-1:0] phase_len();
        return (ticks_cfg == '0) ? TIMER_W'(1) : TIMER_W'(ticks_cfg);
    endfunction

    task automatic drive_phase(input logic [2:0] op, input logic [3:0] ph);
        case (op)
            OP_START:
            begin
                if (ph == PH_0)
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    drv_q = 1'b1;
                end
                else if (ph == PH_1)
                    sda_q = 1'b0;
                else
                    scl_q = 1'b0;
            end
            OP_STOP:
            begin
                if (ph == PH_0)
                begin
                    sda_q = 1'b0;
                    drv_q = 1'b1;
                end
                else if (ph == PH_1)
                    scl_q = 1'b1;
                else
                    sda_q = 1'b1;
            end
            OP_WRITE:
            begin
                if (ph == PH_0)
                begin
                    sda_q = shreg[BYTE_W-1];
                    drv_q = 1'b1;
                end
                else if (ph == PH_1)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end
            OP_READ:
            begin
                if (ph == PH_0)
                    drv_q = 1'b0;
                else if (ph == PH_1)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end
            OP_ACKCHK:
            begin
                if (ph == PH_0)
                    drv_q = 1'b0;
                else if (ph == PH_1)
                    scl_q = 1'b1;
                else if (ph == PH_2)
                    scl_q = 1'b0;
                else
                    drv_q = 1'b1;
            end
            default:
            begin
                if (ph == PH_0)
                    drv_q = 1'b1;
                else if (ph == PH_1)
                    sda_q = 1'b1;
                else if (ph == PH_2)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end
        endcase
    endtask

    task automatic close_phase(input logic s, output logic fin);
        logic [3:0] nxt;
        fin = 1'b0;
        nxt = seq_ph + 4'd1;
        if (cur_op == OP_READ && seq_ph == PH_1)
            shreg = {shreg[BYTE_W-2:0], s};
        if (cur_op == OP_ACKCHK && seq_ph == PH_1)
            ack_q = s;
        if (cur_op == OP_WRITE && seq_ph == PH_2)
        begin
            shreg = {shreg[BYTE_W-2:0], shreg[BYTE_W-1]};
            bits_done = bits_done + 4'd1;
        end
        if (cur_op == OP_READ && seq_ph == PH_2)
            bits_done = bits_done + 4'd1;
        case (cur_op)
            OP_START, OP_STOP:
                fin = (seq_ph >= PH_2);
            OP_WRITE, OP_READ:
            begin
                if (seq_ph == PH_2)
                begin
                    if (bits_done < BYTE_BITS)
                        nxt = (cur_op == OP_WRITE) ? PH_0 : PH_1;
                    else
                        fin = 1'b1;
                end
            end
            default:
                fin = (seq_ph >= PH_3);
        endcase
        if (!fin)
        begin
            seq_ph = nxt;
            drive_phase(cur_op, nxt);
            timer_q = phase_len();
        end
    endtask

    task automatic bus_tick_model(input logic v, input logic [2:0] c, input logic [7:0] b,
                                  input logic s, output res_beat_t r);
        logic fin;
        logic done;
        done = 1'b0;
        if (seq_ph == PH_IDLE)
        begin
            if (v && c <= OP_NACK)
            begin
                cur_op = c;
                bits_done = '0;
                if (c == OP_WRITE)
                    shreg = b;
                if (c == OP_READ)
                    shreg = '0;
                seq_ph = PH_0;
                drive_phase(c, PH_0);
                timer_q = phase_len();
            end
        end
        else if (timer_q > TIMER_W'(1))
            timer_q = timer_q - TIMER_W'(1);
        else
        begin
            close_phase(s, fin);
            if (fin)
            begin
                seq_ph = PH_IDLE;
                timer_q = '0;
                done = 1'b1;
            end
        end
        r.pins.scl = scl_q;
        r.pins.sda = sda_q;
        r.pins.drv = drv_q;
        r.busy = (seq_ph != PH_IDLE);
        r.done = done;
        r.rx_byte = shreg;
        r.ack = ack_q;
    endtask

    function automatic logic [2:0] next_bus_op(input logic [2:0] prev);
        case (prev)
            OP_START:  return OP_WRITE;
            OP_WRITE:  return OP_ACKCHK;
            OP_ACKCHK:
            begin
                case ($urandom_range(0, 3))
                    0:       return OP_WRITE;
                    1:       return OP_READ;
                    2:       return OP_START;
                    default: return OP_STOP;
                endcase
            end
            OP_READ:
            begin
                case ($urandom_range(0, 2))
                    0:       return OP_READ;
                    1:       return OP_ACKCHK;
                    default: return OP_NACK;
                endcase
            end
            OP_NACK:   return ($urandom_range(0, 1) != 0) ? OP_STOP : OP_READ;
            default:   return OP_START;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    endtask

    task automatic send_tick(input logic v, input logic [2:0] c, input logic [7:0] b,
                             input logic s);
        res_beat_t r;
        if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push <= 1'b1;
        cmd_valid <= v;
        cmd <= c;
        tx_byte <= b;
        sda_in <= s;
        do
            @(posedge clk);
        while (full);
        bus_tick_model(v, c, b, s, r);
        bus_res_q.push_back(r);
        @(negedge clk);
    endtask

    task automatic set_phase_ticks(input logic [TICKS_W-1:0] v);
        push <= 1'b0;
        while (bus_res_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ticks_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one command, then ticks until the sequencer is idle again
    task automatic issue_cmd(input logic [2:0] op, input logic [7:0] b, input logic s,
                             input bit noisy);
        send_tick(1'b1, op, b, s);
        while (seq_ph != PH_IDLE)
        begin
            if (noisy)
                send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), s);
            else
                send_tick(1'b0, op, b, s);
        end
    endtask

    // mostly well formed transfers, with stray and out of order commands
    task automatic run_bus_traffic(input int n);
        logic [2:0] c;
        logic v;
        for (int i = 0; i < n; i++)
        begin
            if (seq_ph == PH_IDLE && $urandom_range(0, 9) != 0)
            begin
                v = 1'b1;
                if ($urandom_range(0, 19) == 0)
                    c = 3'($urandom_range(0, 7));
                else
                    c = next_bus_op(cur_op);
            end
            else
            begin
                v = 1'($urandom_range(0, 1));
                c = 3'($urandom_range(0, 7));
            end
            send_tick(v, c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_ticks();
        issue_cmd(OP_START, 8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_directed_cmds();
        set_phase_ticks(TICKS_W'(1));
        issue_cmd(OP_START, 8'h00, 1'b1, 1'b0);
        issue_cmd(OP_ACKCHK, 8'hFF, 1'b0, 1'b0);
        issue_cmd(OP_ACKCHK, 8'h00, 1'b1, 1'b0);
        issue_cmd(OP_NACK, 8'hFF, 1'b0, 1'b0);
        send_tick(1'b1, OP_RSVD6, 8'hA5, 1'b1);
        send_tick(1'b1, OP_RSVD7, 8'h5A, 1'b0);
        issue_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_zero_ticks();
        set_phase_ticks('0);
        run_bus_traffic(120);
    endtask

    task automatic test_random_traffic();
        set_phase_ticks(TICKS_W'(1));
        run_bus_traffic(120);
        set_phase_ticks(TICKS_W'(2));
        run_bus_traffic(100);
        set_phase_ticks(TICKS_W'($urandom_range(3, 6)));
        run_bus_traffic(80);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        set_phase_ticks(TICKS_W'(1));
        run_bus_traffic(250);
    endtask

    task automatic test_max_ticks();
        set_phase_ticks('1);
        send_tick(1'b1, OP_START, 8'h00, 1'b1);
        run_bus_traffic(20);
    endtask

    // result side
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 11) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        res_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (bus_res_q.size() == 0)
                report_mismatch("unexpected result beat", rx_byte, 8'h00);
            else
            begin
                want = bus_res_q.pop_front();
                if (scl_level !== want.pins.scl)
                    report_mismatch("scl_level", 8'(scl_level), 8'(want.pins.scl));
                if (sda_level !== want.pins.sda)
                    report_mismatch("sda_level", 8'(sda_level), 8'(want.pins.sda));
                if (sda_drive !== want.pins.drv)
                    report_mismatch("sda_drive", 8'(sda_drive), 8'(want.pins.drv));
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
                if (done_res !== want.done)
                    report_mismatch("done_res", 8'(done_res), 8'(want.done));
                if (rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", rx_byte, want.rx_byte);
                if (ack_seen !== want.ack)
                    report_mismatch("ack_seen", 8'(ack_seen), 8'(want.ack));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL i2c_bus_master_phy_top");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        cmd_valid = 1'b0;
        cmd = OP_START;
        tx_byte = '0;
        sda_in = 1'b1;
        ticks_cfg = TICKS_W'(250);
        seq_ph = PH_IDLE;
        cur_op = OP_START;
        bits_done = '0;
        timer_q = '0;
        shreg = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        drv_q = 1'b1;
        ack_q = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_ticks();
        test_directed_cmds();
        test_zero_ticks();
        test_random_traffic();
        test_back_to_back();
        test_max_ticks();

        push <= 1'b0;
        while (bus_res_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS i2c_bus_master_phy_top");
        else
            $display("FAIL i2c_bus_master_phy_top");
        $finish;
    end

endmodule
